FILE: hdl/lbm_pkg.sv
// Shared types, constants and a helper function for the LED bar level meter.
package lbm_pkg;

  // Register reset values
  localparam logic [7:0] FLOOR_RESET  = 8'h18;
  localparam logic [4:0] GREEN_RESET  = 5'd15;
  localparam logic [4:0] YELLOW_RESET = 5'd21;

  // Level scaling: level = diff * 23 / 231, done as a multiply by a rounded-up
  // reciprocal and a right shift (exact for every 8-bit diff)
  localparam int SCALE_MUL   = 23;
  localparam int SCALE_DIV   = 231;
  localparam int SCALE_SHIFT = 20;
  localparam int SCALE_RECIP = (((1 << SCALE_SHIFT) + SCALE_DIV - 1) / SCALE_DIV) * SCALE_MUL;
  localparam int PROD_W      = 25;

  localparam logic [4:0] MAX_LEVEL = 5'd23;
  localparam int NUM_BARS          = 24;
  localparam int BARS_PER_GRAPH    = 12;
  localparam int BUF_W             = 48;
  localparam logic [6:0] ADDR_BASE = 7'h70;

  localparam int NUM_CHANNELS_DEF = 7;

  // Field widths
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 5;
  localparam int ADDR_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_FLOOR  = 2'd0,
    CFG_GREEN_LIMIT  = 2'd1,
    CFG_YELLOW_LIMIT = 2'd2
  } lbm_cfg_idx_t;

  // Scaled sample handed from the input stage to the bar stage
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
  } lbm_item_t;

  // Bit position of the red bit of a bar; the green bit sits 8 higher.
  // Bars 12..23 use the high nibble of the same byte pairs.
  function automatic logic [5:0] red_bit(input logic [4:0] bar);
    logic [3:0] b;
    logic [5:0] nib;
    b   = 4'(bar);
    nib = 6'd0;
    if (bar >= 5'(BARS_PER_GRAPH)) begin
      b   = 4'(bar - 5'(BARS_PER_GRAPH));
      nib = 6'd4;
    end
    return {b[3:2], 4'b0000} + {4'b0000, b[1:0]} + nib;
  endfunction

endpackage

FILE: hdl/lbm_scale.sv
// Input stage: takes a sample, drops out-of-range channels, removes the noise floor and scales it to a bar level.
module lbm_scale #(
  parameter int NUM_CHANNELS = lbm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lbm_pkg::CH_W-1:0]      in_channel,
  input  logic [lbm_pkg::SAMPLE_W-1:0]  in_raw_sample,
  input  logic [lbm_pkg::SAMPLE_W-1:0]  noise_floor,
  output logic                          item_valid,
  input  logic                          item_ready,
  output lbm_pkg::lbm_item_t            item
);

  logic                           valid_r;
  logic                           valid_nxt;
  lbm_pkg::lbm_item_t             item_r;
  logic [lbm_pkg::SAMPLE_W-1:0]   diff;
  logic [lbm_pkg::PROD_W-1:0]     prod;
  logic [lbm_pkg::LEVEL_W-1:0]    quot;
  logic [lbm_pkg::LEVEL_W-1:0]    level;
  logic                           ch_ok;
  logic                           accept;

  assign in_ready = !valid_r || item_ready;
  assign accept   = in_valid && in_ready;

  // Floor subtraction, clamped at zero, then scale by 23/231 and saturate
  assign diff  = (in_raw_sample > noise_floor) ? in_raw_sample - noise_floor : '0;
  assign prod  = lbm_pkg::PROD_W'(diff) * lbm_pkg::PROD_W'(lbm_pkg::SCALE_RECIP);
  assign quot  = prod[lbm_pkg::PROD_W-1:lbm_pkg::SCALE_SHIFT];
  assign level = (quot > lbm_pkg::MAX_LEVEL) ? lbm_pkg::MAX_LEVEL : quot;

  // Channels beyond the configured count are dropped here
  assign ch_ok = 5'(in_channel) < 5'(NUM_CHANNELS);

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = ch_ok;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.channel <= in_channel;
      item_r.level   <= level;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hdl/lbm_bars.sv
// Bar stage: per-channel level and bar buffer, rise/decay update and result register.
module lbm_bars #(
  parameter int NUM_CHANNELS = lbm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lbm_pkg::lbm_item_t            item,
  input  logic [lbm_pkg::LEVEL_W-1:0]   green_limit,
  input  logic [lbm_pkg::LEVEL_W-1:0]   yellow_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lbm_pkg::CH_W-1:0]      out_channel,
  output logic [lbm_pkg::ADDR_W-1:0]    out_device_address,
  output logic [lbm_pkg::LEVEL_W-1:0]   out_shown_level,
  output logic [lbm_pkg::BUF_W-1:0]     out_display_bytes
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Per-channel state
  logic [lbm_pkg::LEVEL_W-1:0] lvl_r [NUM_CHANNELS];
  logic [lbm_pkg::BUF_W-1:0]   buf_r [NUM_CHANNELS];

  logic [CH_IDX_W-1:0]         ch_idx;
  logic [lbm_pkg::LEVEL_W-1:0] old_level;
  logic [lbm_pkg::LEVEL_W-1:0] lvl_nxt;
  logic [lbm_pkg::BUF_W-1:0]   buf_nxt;
  logic                        rising;
  logic                        falling;
  logic                        consume;
  logic                        update;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [lbm_pkg::CH_W-1:0]    out_channel_r;
  logic [lbm_pkg::ADDR_W-1:0]  out_addr_r;
  logic [lbm_pkg::LEVEL_W-1:0] out_level_r;
  logic [lbm_pkg::BUF_W-1:0]   out_bytes_r;

  assign item_ready = !out_valid_r || out_ready;
  assign consume    = item_valid && item_ready;

  assign ch_idx    = CH_IDX_W'(item.channel);
  assign old_level = lvl_r[ch_idx];
  assign rising    = item.level > old_level;
  assign falling   = item.level < old_level;
  assign update    = consume && (rising || falling);
  assign lvl_nxt   = rising ? item.level : old_level - 5'd1;

  // Paint the range old..new on a rise, clear the bar at the old level on decay
  always_comb begin
    logic [4:0] bar;
    logic [5:0] rb;
    buf_nxt = buf_r[ch_idx];
    for (int i = 0; i < lbm_pkg::NUM_BARS; i++) begin
      bar = 5'(i);
      rb  = lbm_pkg::red_bit(bar);
      if (rising && bar >= old_level && bar <= item.level) begin
        buf_nxt[rb]          = bar >= green_limit;
        buf_nxt[6'(rb + 6'd8)] = (bar < green_limit) || (bar < yellow_limit);
      end else if (falling && bar == old_level) begin
        buf_nxt[rb]          = 1'b0;
        buf_nxt[6'(rb + 6'd8)] = 1'b0;
      end
    end
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        lvl_r[c] <= '0;
        buf_r[c] <= '0;
      end
    end else if (update) begin
      lvl_r[ch_idx] <= lvl_nxt;
      buf_r[ch_idx] <= buf_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_channel_r <= item.channel;
      out_addr_r    <= lbm_pkg::ADDR_BASE + lbm_pkg::ADDR_W'(item.channel);
      out_level_r   <= lvl_nxt;
      out_bytes_r   <= buf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_channel_r;
  assign out_device_address = out_addr_r;
  assign out_shown_level    = out_level_r;
  assign out_display_bytes  = out_bytes_r;

  // Checks
  a_result_follows_change: assert property (@(posedge clk) disable iff (!rst_n)
    update |=> out_valid_r && out_channel_r == $past(item.channel))
    else $error("changed level did not produce a transaction");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= lbm_pkg::MAX_LEVEL)
    else $error("shown level above maximum");

  a_rise_takes_level: assert property (@(posedge clk) disable iff (!rst_n)
    (update && rising) |=> out_level_r == $past(item.level))
    else $error("rise did not take new level");

  a_decay_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (update && falling) |=> out_level_r == $past(old_level) - 5'd1)
    else $error("decay did not step down by one");

  a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !consume)
    else $error("item consumed while result stalled");

endmodule

FILE: hdl/led_bar_level_meter.sv
// LED bar level meter: takes one band sample per transaction and emits the updated bar
// display of that channel. Up to one transaction is accepted every clock cycle while
// in_ready is high; a result passes through the input stage register and then the
// result register, which is loaded together with the per-channel state update. Samples
// that leave a channel's level unchanged, or name a channel at or above NUM_CHANNELS,
// produce no result. While a result waits on out_ready, the input stage still holds one
// more sample before in_ready drops. Configuration registers take effect immediately;
// the user must write them only while idle, as the block itself does not enforce this.
module led_bar_level_meter #(
  parameter int NUM_CHANNELS = lbm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lbm_pkg::CH_W-1:0]        in_channel,
  input  logic [lbm_pkg::SAMPLE_W-1:0]    in_raw_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lbm_pkg::CH_W-1:0]        out_channel,
  output logic [lbm_pkg::ADDR_W-1:0]      out_device_address,
  output logic [lbm_pkg::LEVEL_W-1:0]     out_shown_level,
  output logic [lbm_pkg::BUF_W-1:0]       out_display_bytes
);

  logic [lbm_pkg::SAMPLE_W-1:0] noise_floor_r;
  logic [lbm_pkg::LEVEL_W-1:0]  green_limit_r;
  logic [lbm_pkg::LEVEL_W-1:0]  yellow_limit_r;

  logic                         item_valid;
  logic                         item_ready;
  lbm_pkg::lbm_item_t           item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_floor_r  <= lbm_pkg::FLOOR_RESET;
      green_limit_r  <= lbm_pkg::GREEN_RESET;
      yellow_limit_r <= lbm_pkg::YELLOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbm_pkg::CFG_NOISE_FLOOR:  noise_floor_r  <= cfg_data;
        lbm_pkg::CFG_GREEN_LIMIT:  green_limit_r  <= cfg_data[lbm_pkg::LEVEL_W-1:0];
        lbm_pkg::CFG_YELLOW_LIMIT: yellow_limit_r <= cfg_data[lbm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  lbm_scale #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_channel    (in_channel),
    .in_raw_sample (in_raw_sample),
    .noise_floor   (noise_floor_r),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  lbm_bars #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_bars (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item               (item),
    .green_limit        (green_limit_r),
    .yellow_limit       (yellow_limit_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_device_address (out_device_address),
    .out_shown_level    (out_shown_level),
    .out_display_bytes  (out_display_bytes)
  );

endmodule
